/* design/dmm_lcd_frame_decoder_top_defines.svh */
// Assertion macros shared by the frame decoder RTL
`ifndef DMM_LCD_FRAME_DECODER_TOP_DEFINES_SVH
`define DMM_LCD_FRAME_DECODER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define DLFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define DLFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dlfd_pkg.sv */
// Types, codes and the digit decoder of the meter LCD frame decoder
package dlfd_pkg;

   localparam int FRAME_LEN       = 14;
   localparam int QUEUE_DEPTH_DEF = 2;

   typedef logic [3:0] nibble_type;
   typedef logic [3:0] digit_type;
   typedef logic [FRAME_LEN-1:0][3:0] frame_type;

   // segment numbers
   localparam nibble_type SEG_NUM_FIRST = 4'd1;

   // digit codes beyond the numeric values
   localparam digit_type DIGIT_BLANK    = 4'd10;
   localparam digit_type DIGIT_LETTER_L = 4'd11;
   localparam digit_type DIGIT_UNKNOWN  = 4'd12;

   // seven-segment patterns, point bit removed
   localparam logic [6:0] SEG_0     = 7'h7d;
   localparam logic [6:0] SEG_1     = 7'h05;
   localparam logic [6:0] SEG_2     = 7'h5b;
   localparam logic [6:0] SEG_3     = 7'h1f;
   localparam logic [6:0] SEG_4     = 7'h27;
   localparam logic [6:0] SEG_5     = 7'h3e;
   localparam logic [6:0] SEG_6     = 7'h7e;
   localparam logic [6:0] SEG_7     = 7'h15;
   localparam logic [6:0] SEG_8     = 7'h7f;
   localparam logic [6:0] SEG_9     = 7'h3f;
   localparam logic [6:0] SEG_BLANK = 7'h00;
   localparam logic [6:0] SEG_L     = 7'h68;

   localparam logic [2:0] PREFIX_NONE  = 3'd0;
   localparam logic [2:0] PREFIX_NANO  = 3'd1;
   localparam logic [2:0] PREFIX_MICRO = 3'd2;
   localparam logic [2:0] PREFIX_MILLI = 3'd3;
   localparam logic [2:0] PREFIX_KILO  = 3'd4;
   localparam logic [2:0] PREFIX_MEGA  = 3'd5;

   localparam logic [2:0] UNIT_NONE    = 3'd0;
   localparam logic [2:0] UNIT_FARAD   = 3'd1;
   localparam logic [2:0] UNIT_OHM     = 3'd2;
   localparam logic [2:0] UNIT_AMP     = 3'd3;
   localparam logic [2:0] UNIT_VOLT    = 3'd4;
   localparam logic [2:0] UNIT_HERTZ   = 3'd5;
   localparam logic [2:0] UNIT_PERCENT = 3'd6;
   localparam logic [2:0] UNIT_CELSIUS = 3'd7;

   // status flag bit positions
   localparam int FLAG_AC       = 0;
   localparam int FLAG_RELATIVE = 1;
   localparam int FLAG_HOLD     = 2;
   localparam int FLAG_LOW_BATT = 3;
   localparam int FLAG_DIODE    = 4;
   localparam int FLAG_BEEP     = 5;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      digit_type  digit_one;
      digit_type  digit_two;
      digit_type  digit_three;
      digit_type  digit_four;
      logic       negative;
      logic [2:0] point_mask;
      logic [2:0] prefix;
      logic [2:0] unit;
      logic [5:0] status_flags;
   } rsp_type;

   function automatic digit_type decode_digit(nibble_type hi, nibble_type lo);
      logic [6:0] pat;
      digit_type  code;
      pat = {hi[2:0], lo};
      unique case (pat)
         SEG_0:     code = 4'd0;
         SEG_1:     code = 4'd1;
         SEG_2:     code = 4'd2;
         SEG_3:     code = 4'd3;
         SEG_4:     code = 4'd4;
         SEG_5:     code = 4'd5;
         SEG_6:     code = 4'd6;
         SEG_7:     code = 4'd7;
         SEG_8:     code = 4'd8;
         SEG_9:     code = 4'd9;
         SEG_BLANK: code = DIGIT_BLANK;
         SEG_L:     code = DIGIT_LETTER_L;
         default:   code = DIGIT_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

/* design/dlfd_channels.sv */
// Valid/ready channel interfaces for received bytes and decoded readings
interface dlfd_req_if;
   import dlfd_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dlfd_rsp_if;
   import dlfd_pkg::*;
   logic       valid;
   logic       ready;
   digit_type  digit_one;
   digit_type  digit_two;
   digit_type  digit_three;
   digit_type  digit_four;
   logic       negative;
   logic [2:0] point_mask;
   logic [2:0] prefix;
   logic [2:0] unit;
   logic [5:0] status_flags;

   modport source (output valid, output digit_one, output digit_two, output digit_three,
                   output digit_four, output negative, output point_mask, output prefix,
                   output unit, output status_flags, input ready);
   modport sink   (input valid, input digit_one, input digit_two, input digit_three,
                   input digit_four, input negative, input point_mask, input prefix,
                   input unit, input status_flags, output ready);
endinterface

/* design/dlfd_front.sv */
// Front end: frame sync on segment numbers and nibble capture
module dlfd_front (
   input  logic                   clock,
   input  logic                   reset,
   dlfd_req_if.sink               req_chan,
   output logic                   push,
   output dlfd_pkg::frame_type    push_data,
   input  dlfd_pkg::q_status_type q_status
);
   import dlfd_pkg::*;

   localparam logic [3:0] LAST_HELD = 4'(FRAME_LEN - 1);

   logic [3:0]                   held_ff, held_in;
   logic [FRAME_LEN-2:0][3:0]    nib_ff;
   logic                         accept;
   logic                         in_seq;
   nibble_type                   seg;
   nibble_type                   nib;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign seg            = req_chan.rx_byte[7:4];
   assign nib            = req_chan.rx_byte[3:0];

   // segment 0 and 15 never match: held stays in 1..13 here
   assign in_seq = (held_ff != 4'd0) && (held_ff <= LAST_HELD) && (seg == held_ff + 4'd1);

   assign push      = accept && in_seq && (held_ff == LAST_HELD);
   assign push_data = {nib, nib_ff};

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         priority if (in_seq) begin
            held_in = (held_ff == LAST_HELD) ? 4'd0 : held_ff + 4'd1;
         end else if (seg == SEG_NUM_FIRST) begin
            held_in = 4'd1;
         end else begin
            held_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 4'd0;
      end else begin
         held_ff <= held_in;
      end
   end

   // capture the payload nibble at its slot; the last one goes straight to the queue
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < FRAME_LEN - 1; i++) begin
            if (in_seq && held_ff == 4'(i)) begin
               nib_ff[i] <= nib;
            end else if (!in_seq && seg == SEG_NUM_FIRST && i == 0) begin
               nib_ff[i] <= nib;
            end
         end
      end
   end

endmodule

/* design/dlfd_queue.sv */
// Short queue of complete frames between front and back end
module dlfd_queue #(
   parameter int QUEUE_DEPTH = dlfd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dlfd_pkg::frame_type    push_data,
   input  logic                   pop,
   output dlfd_pkg::frame_type    head,
   output dlfd_pkg::q_status_type status
);
   import dlfd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/dlfd_back.sv */
// Back end: decodes a queued frame into the registered reading
module dlfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dlfd_pkg::frame_type    head,
   input  dlfd_pkg::q_status_type q_status,
   output logic                   pop,
   dlfd_rsp_if.source             rsp_chan
);
   import dlfd_pkg::*;

   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   nibble_type na, nb, nc, nd, ne;

   assign na = head[9];
   assign nb = head[10];
   assign nc = head[11];
   assign nd = head[12];
   assign ne = head[13];

   // load a new reading when the output stage is empty or draining
   assign pop      = !q_status.empty && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);

   always_comb begin
      rsp_in             = '0;
      rsp_in.digit_one   = decode_digit(head[1], head[2]);
      rsp_in.digit_two   = decode_digit(head[3], head[4]);
      rsp_in.digit_three = decode_digit(head[5], head[6]);
      rsp_in.digit_four  = decode_digit(head[7], head[8]);
      rsp_in.negative    = head[1][3];
      rsp_in.point_mask  = {head[7][3], head[5][3], head[3][3]};

      priority if (na[2]) begin
         rsp_in.prefix = PREFIX_NANO;
      end else if (na[3]) begin
         rsp_in.prefix = PREFIX_MICRO;
      end else if (nb[3]) begin
         rsp_in.prefix = PREFIX_MILLI;
      end else if (na[1]) begin
         rsp_in.prefix = PREFIX_KILO;
      end else if (nb[1]) begin
         rsp_in.prefix = PREFIX_MEGA;
      end else begin
         rsp_in.prefix = PREFIX_NONE;
      end

      priority if (nc[3]) begin
         rsp_in.unit = UNIT_FARAD;
      end else if (nc[2]) begin
         rsp_in.unit = UNIT_OHM;
      end else if (nd[3]) begin
         rsp_in.unit = UNIT_AMP;
      end else if (nd[2]) begin
         rsp_in.unit = UNIT_VOLT;
      end else if (nd[1]) begin
         rsp_in.unit = UNIT_HERTZ;
      end else if (nb[2]) begin
         rsp_in.unit = UNIT_PERCENT;
      end else if (ne[0]) begin
         rsp_in.unit = UNIT_CELSIUS;
      end else begin
         rsp_in.unit = UNIT_NONE;
      end

      rsp_in.status_flags[FLAG_AC]       = head[0][3];
      rsp_in.status_flags[FLAG_RELATIVE] = nc[1];
      rsp_in.status_flags[FLAG_HOLD]     = nc[0];
      rsp_in.status_flags[FLAG_LOW_BATT] = nd[0];
      rsp_in.status_flags[FLAG_DIODE]    = na[0];
      rsp_in.status_flags[FLAG_BEEP]     = nb[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.digit_one    = rsp_ff.digit_one;
   assign rsp_chan.digit_two    = rsp_ff.digit_two;
   assign rsp_chan.digit_three  = rsp_ff.digit_three;
   assign rsp_chan.digit_four   = rsp_ff.digit_four;
   assign rsp_chan.negative     = rsp_ff.negative;
   assign rsp_chan.point_mask   = rsp_ff.point_mask;
   assign rsp_chan.prefix       = rsp_ff.prefix;
   assign rsp_chan.unit         = rsp_ff.unit;
   assign rsp_chan.status_flags = rsp_ff.status_flags;

endmodule

/* design/dmm_lcd_frame_decoder_top.sv */
// Top level of the meter LCD frame decoder
//
//   channel    dir  beat                          handshake
//   req_chan   in   one serial byte (rx_byte)     valid/ready
//   rsp_chan   out  one decoded reading           valid/ready
//
// One byte per cycle is taken while the frame queue has room.
// After its fourteenth byte is accepted, a reading passes the frame queue and then the
// output register; it waits in the queue while the output register holds an untaken reading.
// req_chan.ready drops only when the frame queue is full; the output register
// keeps its reading while rsp_chan.ready is low.
// Synchronous reset clears frame sync, queue and output valid; no clearing pass.
`include "dmm_lcd_frame_decoder_top_defines.svh"

module dmm_lcd_frame_decoder_top #(
   parameter int QUEUE_DEPTH = dlfd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dlfd_req_if.sink   req_chan,
   dlfd_rsp_if.source rsp_chan
);
   import dlfd_pkg::*;

   logic         q_push;
   logic         q_pop;
   frame_type    q_push_data;
   frame_type    q_head;
   q_status_type q_status;

   dlfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push      (q_push),
      .push_data (q_push_data),
      .q_status  (q_status)
   );

   dlfd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   dlfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   `DLFD_ASSERT_SAME(a_no_push_when_full, clock, reset, q_push, !q_status.full, "frame pushed into full queue")
   `DLFD_ASSERT_NEXT(a_push_fills_queue, clock, reset, q_push && !q_pop, !q_status.empty, "pushed frame lost")
   `DLFD_ASSERT_SAME(a_rsp_from_queue, clock, reset, $rose(rsp_chan.valid), $past(!q_status.empty), "reading without frame")
   `DLFD_ASSERT_SAME(a_prefix_range, clock, reset, rsp_chan.valid, rsp_chan.prefix <= PREFIX_MEGA, "prefix code out of range")

endmodule
